// File: rtl/tfp_pkg.sv
// ============================================================================
// tfp_pkg: shared types and constants of the telematics frame packer
// Item structs, queued operation format, sequencer phases and framing bytes.
// ============================================================================
`default_nettype none

package tfp_pkg;

    localparam logic CMD_HEADER  = 1'b0;
    localparam logic CMD_CONTENT = 1'b1;

    localparam logic [7:0] FLAG_BYTE  = 8'h7e;
    localparam logic [7:0] ESC_BYTE   = 8'h7d;
    localparam logic [7:0] ESC_FLAG   = 8'h02;
    localparam logic [7:0] ESC_ESC    = 8'h01;
    localparam logic [7:0] SUBPKG_BIT = 8'h20;

    localparam int          HDR_BYTES      = 16;
    localparam logic [3:0]  HDR_LAST_SHORT = 4'd11;
    localparam logic [3:0]  HDR_LAST_LONG  = 4'd15;

    typedef struct packed {
        logic        cmd;
        logic [15:0] msg_id;
        logic [15:0] serial;
        logic [47:0] terminal_bcd;
        logic [15:0] pkg_count;
        logic [15:0] pkg_index;
        logic [9:0]  body_len;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    typedef enum logic {
        OP_HEADER  = 1'b0,
        OP_CONTENT = 1'b1
    } op_kind_t;

    typedef struct packed {
        op_kind_t                      kind;
        logic                          close;
        logic [3:0]                    hdr_last;
        logic [HDR_BYTES-1:0][7:0]     hdr_bytes;
        logic [7:0]                    data_byte;
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_FLAG_OPEN  = 3'd1,
        PH_HDR        = 3'd2,
        PH_DATA       = 3'd3,
        PH_SUM        = 3'd4,
        PH_FLAG_CLOSE = 3'd5
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/telematics_frame_packer_unit.sv
// ============================================================================
// telematics_frame_packer_unit: flagged, byte-stuffed message frame builder
// Header transactions open a frame, content transactions add payload bytes.
// ----------------------------------------------------------------------------
// input channel: push/full, one transaction per in_item; cmd header opens a
//   frame, cmd content adds one byte (dropped when no frame is open)
// result channel: empty/pop, one stuffed line byte per transaction,
//   frame_end marks the closing flag
// the front stage updates frame state and queues operations; the back stage
//   serialises one line byte per cycle from the queue head unless stalled
// an item's first byte goes through a queue entry, then the output register
// throughput: one line byte per cycle unless the receiver stalls; escaped
//   bytes take two line bytes, and a frame close adds checksum and flag
// input accepted while the queue has room (QUEUE_DEPTH operations)
// a stalled receiver holds the output register; the queue then fills and
//   full rises
// reset clears frame state, queue pointers and output valid flag; no clearing pass
// ============================================================================
`default_nettype none

module telematics_frame_packer_unit
    import tfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     out_item
);

    logic q_push;
    op_t  q_op;
    logic q_full;
    logic q_pop;
    op_t  q_head;
    logic q_empty;

    tfp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .q_push  (q_push),
        .q_op    (q_op),
        .q_full  (q_full)
    );

    tfp_op_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_op   (q_op),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_op   (q_head),
        .q_empty (q_empty)
    );

    tfp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

// File: rtl/tfp_front.sv
// ============================================================================
// tfp_front: input side of the frame packer
// Accepts items, tracks frame progress and queues header/content operations.
// ============================================================================
`default_nettype none

module tfp_front
    import tfp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t in_item,
    output logic          q_push,
    output op_t           q_op,
    input  wire logic     q_full
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [9:0] bytes_left_reg;
    logic [9:0] bytes_left_next;
    logic       accept;
    logic [7:0] prop_hi;
    logic       has_pkg;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign has_pkg = |in_item.pkg_count;
    assign prop_hi = (has_pkg ? SUBPKG_BIT : 8'h00) | {6'b0, in_item.body_len[9:8]};

    always_comb
    begin
        q_op               = '0;
        q_push             = 1'b0;
        in_frame_next      = in_frame_reg;
        bytes_left_next    = bytes_left_reg;
        q_op.data_byte     = in_item.data_byte;
        q_op.hdr_last      = has_pkg ? HDR_LAST_LONG : HDR_LAST_SHORT;
        q_op.hdr_bytes[0]  = in_item.msg_id[15:8];
        q_op.hdr_bytes[1]  = in_item.msg_id[7:0];
        q_op.hdr_bytes[2]  = prop_hi;
        q_op.hdr_bytes[3]  = in_item.body_len[7:0];
        q_op.hdr_bytes[4]  = in_item.terminal_bcd[47:40];
        q_op.hdr_bytes[5]  = in_item.terminal_bcd[39:32];
        q_op.hdr_bytes[6]  = in_item.terminal_bcd[31:24];
        q_op.hdr_bytes[7]  = in_item.terminal_bcd[23:16];
        q_op.hdr_bytes[8]  = in_item.terminal_bcd[15:8];
        q_op.hdr_bytes[9]  = in_item.terminal_bcd[7:0];
        q_op.hdr_bytes[10] = in_item.serial[15:8];
        q_op.hdr_bytes[11] = in_item.serial[7:0];
        q_op.hdr_bytes[12] = in_item.pkg_count[15:8];
        q_op.hdr_bytes[13] = in_item.pkg_count[7:0];
        q_op.hdr_bytes[14] = in_item.pkg_index[15:8];
        q_op.hdr_bytes[15] = in_item.pkg_index[7:0];
        if (in_item.cmd == CMD_HEADER)
        begin
            q_op.kind  = OP_HEADER;
            q_op.close = (in_item.body_len == 10'd0);
            if (accept)
            begin
                q_push          = 1'b1;
                in_frame_next   = (in_item.body_len != 10'd0);
                bytes_left_next = in_item.body_len;
            end
        end
        else
        begin
            q_op.kind  = OP_CONTENT;
            q_op.close = (bytes_left_reg == 10'd1);
            // content outside a frame is dropped
            if (accept && in_frame_reg)
            begin
                q_push          = 1'b1;
                in_frame_next   = (bytes_left_reg != 10'd1);
                bytes_left_next = bytes_left_reg - 10'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 10'd0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tfp_op_fifo.sv
// ============================================================================
// tfp_op_fifo: operation queue between front and back
// Register-based first-in first-out queue with the head shown combinationally.
// ============================================================================
`default_nettype none

module tfp_op_fifo
    import tfp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire op_t  wr_op,
    output logic      q_full,
    input  wire logic rd_en,
    output op_t       rd_op,
    output logic      q_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_op   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tfp_back.sv
// ============================================================================
// tfp_back: byte sequencer of the frame packer
// Walks queued operations, escapes bytes, keeps the checksum, drives output.
// ============================================================================
`default_nettype none

module tfp_back
    import tfp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire op_t  head,
    input  wire logic q_empty,
    output logic      q_pop,
    output logic      empty,
    input  wire logic pop,
    output out_item_t out_item
);

    phase_t     phase_reg;
    phase_t     phase_next;
    phase_t     eff_phase;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic       esc_reg;
    logic       esc_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_item_t  out_item_reg;
    out_item_t  out_item_d;
    logic [7:0] cur_raw;
    logic       is_special;
    logic       emit;
    logic       slot_done;
    logic       go;
    logic       step;

    assign empty    = !out_valid_reg;
    assign out_item = out_item_reg;
    assign go       = !out_valid_reg || pop;
    assign step     = emit && go;

    // a waiting head operation starts at once, not by way of the idle phase
    always_comb
    begin
        if (phase_reg == PH_IDLE)
        begin
            if (q_empty)
            begin
                eff_phase = PH_IDLE;
            end
            else
            begin
                eff_phase = (head.kind == OP_HEADER) ? PH_FLAG_OPEN : PH_DATA;
            end
        end
        else
        begin
            eff_phase = phase_reg;
        end
    end

    always_comb
    begin
        case (eff_phase)
            PH_HDR:  cur_raw = head.hdr_bytes[pos_reg];
            PH_DATA: cur_raw = head.data_byte;
            PH_SUM:  cur_raw = xor_reg;
            default: cur_raw = 8'h00;
        endcase
    end

    assign is_special = (cur_raw == FLAG_BYTE) || (cur_raw == ESC_BYTE);

    // output decode
    always_comb
    begin
        emit       = 1'b0;
        slot_done  = 1'b0;
        out_item_d = '0;
        unique case (eff_phase) inside
            PH_IDLE:
            begin
                emit = 1'b0;
            end
            PH_FLAG_OPEN:
            begin
                emit                = 1'b1;
                slot_done           = 1'b1;
                out_item_d.out_byte = FLAG_BYTE;
            end
            PH_FLAG_CLOSE:
            begin
                emit                 = 1'b1;
                slot_done            = 1'b1;
                out_item_d.out_byte  = FLAG_BYTE;
                out_item_d.frame_end = 1'b1;
            end
            PH_HDR, PH_DATA, PH_SUM:
            begin
                emit = 1'b1;
                if (esc_reg)
                begin
                    slot_done           = 1'b1;
                    out_item_d.out_byte = (cur_raw == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
                end
                else if (is_special)
                begin
                    slot_done           = 1'b0;
                    out_item_d.out_byte = ESC_BYTE;
                end
                else
                begin
                    slot_done           = 1'b1;
                    out_item_d.out_byte = cur_raw;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        esc_next   = step ? !slot_done : esc_reg;
        q_pop      = 1'b0;
        if (step && slot_done)
        begin
            unique case (eff_phase)
                PH_FLAG_OPEN:
                begin
                    phase_next = PH_HDR;
                    pos_next   = 4'd0;
                    xor_next   = 8'h00;
                end
                PH_HDR:
                begin
                    xor_next = xor_reg ^ cur_raw;
                    if (pos_reg == head.hdr_last)
                    begin
                        pos_next = 4'd0;
                        if (head.close)
                        begin
                            phase_next = PH_SUM;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            q_pop      = 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                PH_DATA:
                begin
                    xor_next = xor_reg ^ cur_raw;
                    if (head.close)
                    begin
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        q_pop      = 1'b1;
                    end
                end
                PH_SUM:
                begin
                    phase_next = PH_FLAG_CLOSE;
                end
                PH_FLAG_CLOSE:
                begin
                    phase_next = PH_IDLE;
                    q_pop      = 1'b1;
                end
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= 4'd0;
            esc_reg       <= 1'b0;
            xor_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            esc_reg       <= esc_next;
            xor_reg       <= xor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= out_item_d;
        end
    end

endmodule

`default_nettype wire
